/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the semaphore unit.
// Each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/mtsu_pkg.sv */
// Package of the multi-token semaphore unit: operation, result and error codes.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

package mtsu_pkg;

    // Width of the semaphore descriptor fields.
    localparam int SEM_W = 4;

    // Operation codes.
    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_LOCK   = 2'd1;
    localparam logic [1:0] FUNC_UNLOCK = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_CREATED = 3'd0;
    localparam logic [2:0] KIND_GRANTED = 3'd1;
    localparam logic [2:0] KIND_QUEUED  = 3'd2;
    localparam logic [2:0] KIND_UNLOCK  = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN    = 3'd1;
    localparam logic [2:0] ERR_TABLE_FULL = 3'd2;
    localparam logic [2:0] ERR_QUEUE_FULL = 3'd3;
    localparam logic [2:0] ERR_NO_SLEEP   = 3'd4;

endpackage

/* rtl/multi_token_semaphore_unit.sv */
// Multi-token semaphore unit: counting semaphores sharing one FIFO of waiters.
// Create: result registered straight from idle, a new create may follow at once.
// Lock: the lookup state reads the count and its result is registered; busy during the lookup.
// Unlock: lookup, a walk over the queued waiters, then a done state; the walk reads one queue entry a cycle.
// Reset clears state, counts and sleep_enable (to 1); memories are not cleared.
// Results cannot be stalled: each is shown for one cycle under strobe.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_token_semaphore_unit #(
    parameter int NUM_SEMS       = 16,
    parameter int QUEUE_DEPTH    = 16,
    parameter int TOKEN_BITS     = 16,
    parameter int REQUESTER_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  func,
    input  logic [mtsu_pkg::SEM_W-1:0]  sem_id,
    input  logic [TOKEN_BITS-1:0]       request_tokens,
    input  logic [REQUESTER_BITS-1:0]   requester,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    output logic                        strobe,
    output logic [2:0]                  result_kind,
    output logic [mtsu_pkg::SEM_W-1:0]  sem_out,
    output logic [REQUESTER_BITS-1:0]   requester_out,
    output logic [2:0]                  error_code,
    output logic [TOKEN_BITS-1:0]       tokens_left,
    output logic                        last
);

    localparam int SEM_W  = mtsu_pkg::SEM_W;
    localparam int SEM_AW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int CNT_W  = $clog2(NUM_SEMS + 1);
    localparam int CMP_W  = (CNT_W > SEM_W) ? CNT_W : SEM_W;
    localparam int QAW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W  = SEM_W + TOKEN_BITS + REQUESTER_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          created_reg, created_next;
    logic [QCNT_W-1:0]         qcount_reg, qcount_next;
    logic [QCNT_W-1:0]         idx_reg, idx_next;
    logic [QCNT_W-1:0]         wr_reg, wr_next;
    logic                      grant_on_reg, grant_on_next;
    logic                      sleep_reg, sleep_next;
    logic                      unlock_reg, unlock_next;
    logic [SEM_W-1:0]          sid_reg, sid_next;
    logic [TOKEN_BITS-1:0]     req_reg, req_next;
    logic [REQUESTER_BITS-1:0] who_reg, who_next;
    logic [TOKEN_BITS-1:0]     tok_reg, tok_next;

    logic                      strobe_reg, strobe_next;
    logic [2:0]                kind_reg, kind_next;
    logic [SEM_W-1:0]          semo_reg, semo_next;
    logic [REQUESTER_BITS-1:0] whoo_reg, whoo_next;
    logic [2:0]                err_reg, err_next;
    logic [TOKEN_BITS-1:0]     toko_reg, toko_next;
    logic                      last_reg, last_next;

    // Memory port signals.
    logic                  sem_we;
    logic [SEM_AW-1:0]     sem_waddr;
    logic [TOKEN_BITS-1:0] sem_wdata;
    logic [SEM_AW-1:0]     sem_raddr;
    logic [TOKEN_BITS-1:0] sem_rdata;
    logic                  q_we;
    logic [QAW-1:0]        q_waddr;
    logic [ENT_W-1:0]      q_wdata;
    logic [QAW-1:0]        q_raddr;
    logic [ENT_W-1:0]      q_rdata;

    // Fields of the queue entry under evaluation and walk helpers.
    logic [SEM_W-1:0]          ent_sem;
    logic [TOKEN_BITS-1:0]     ent_need;
    logic [REQUESTER_BITS-1:0] ent_who;
    logic [TOKEN_BITS:0]       sat_sum;
    logic [TOKEN_BITS-1:0]     tok_after;
    logic [QCNT_W-1:0]         idx_inc;
    logic                      take;

    // Token counts per semaphore; entries are written at create before any read.
    mtsu_ram #(
        .WIDTH (TOKEN_BITS),
        .DEPTH (NUM_SEMS)
    ) u_sem_ram (
        .clk   (clk),
        .we    (sem_we),
        .waddr (sem_waddr),
        .wdata (sem_wdata),
        .raddr (sem_raddr),
        .rdata (sem_rdata)
    );

    // Waiter queue; entries below the fill count are valid, in arrival order.
    mtsu_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign {ent_sem, ent_need, ent_who} = q_rdata;
    assign sat_sum   = {1'b0, sem_rdata} + {1'b0, req_reg};
    assign tok_after = tok_reg - ent_need;
    assign idx_inc   = idx_reg + QCNT_W'(1);
    assign take      = grant_on_reg && (ent_sem == sid_reg) && (ent_need <= tok_reg);
    assign sem_raddr = SEM_AW'(sem_id);

    // Sequencer: lookup, then one queue entry per cycle through the grant compare.
    always_comb
    begin
        state_next    = state_reg;
        created_next  = created_reg;
        qcount_next   = qcount_reg;
        idx_next      = idx_reg;
        wr_next       = wr_reg;
        grant_on_next = grant_on_reg;
        sleep_next    = cfg_we ? cfg_wdata : sleep_reg;
        unlock_next   = unlock_reg;
        sid_next      = sid_reg;
        req_next      = req_reg;
        who_next      = who_reg;
        tok_next      = tok_reg;

        strobe_next = 1'b0;
        kind_next   = kind_reg;
        semo_next   = semo_reg;
        whoo_next   = whoo_reg;
        err_next    = err_reg;
        toko_next   = toko_reg;
        last_next   = last_reg;

        sem_we    = 1'b0;
        sem_waddr = created_reg[SEM_AW-1:0];
        sem_wdata = request_tokens;
        q_we      = 1'b0;
        q_waddr   = qcount_reg[QAW-1:0];
        q_wdata   = {sid_reg, req_reg, who_reg};
        q_raddr   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sid_next    = sem_id;
                    req_next    = request_tokens;
                    who_next    = requester;
                    unlock_next = (func == mtsu_pkg::FUNC_UNLOCK);
                    unique case (func) inside
                        mtsu_pkg::FUNC_CREATE:
                        begin
                            strobe_next = 1'b1;
                            whoo_next   = '0;
                            last_next   = 1'b1;
                            if (created_reg >= CNT_W'(NUM_SEMS))
                            begin
                                kind_next = mtsu_pkg::KIND_ERROR;
                                semo_next = '0;
                                err_next  = mtsu_pkg::ERR_TABLE_FULL;
                                toko_next = '0;
                            end
                            else
                            begin
                                sem_we       = 1'b1;
                                created_next = created_reg + CNT_W'(1);
                                kind_next    = mtsu_pkg::KIND_CREATED;
                                semo_next    = SEM_W'(created_reg);
                                err_next     = mtsu_pkg::ERR_NONE;
                                toko_next    = request_tokens;
                            end
                        end
                        mtsu_pkg::FUNC_LOCK, mtsu_pkg::FUNC_UNLOCK:
                        begin
                            if (CMP_W'(sem_id) >= CMP_W'(created_reg))
                            begin
                                strobe_next = 1'b1;
                                kind_next   = mtsu_pkg::KIND_ERROR;
                                semo_next   = sem_id;
                                whoo_next   = '0;
                                err_next    = mtsu_pkg::ERR_UNKNOWN;
                                toko_next   = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_LOOKUP;
                            end
                        end
                        mtsu_pkg::FUNC_NONE:
                        begin
                            // Unused operation: the transfer is taken and dropped.
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_LOOKUP:
            begin
                semo_next = sid_reg;
                err_next  = mtsu_pkg::ERR_NONE;
                sem_waddr = SEM_AW'(sid_reg);
                if (unlock_reg)
                begin
                    // Saturating release, then walk the queue from its head if it holds any waiter.
                    tok_next      = sat_sum[TOKEN_BITS] ? '1 : sat_sum[TOKEN_BITS-1:0];
                    idx_next      = '0;
                    wr_next       = '0;
                    grant_on_next = 1'b1;
                    q_raddr       = '0;
                    state_next    = (qcount_reg == '0) ? ST_DONE : ST_WALK;
                end
                else
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    whoo_next   = '0;
                    toko_next   = sem_rdata;
                    state_next  = ST_IDLE;
                    if (sem_rdata >= req_reg)
                    begin
                        sem_we    = 1'b1;
                        sem_wdata = sem_rdata - req_reg;
                        kind_next = mtsu_pkg::KIND_GRANTED;
                        whoo_next = who_reg;
                        toko_next = sem_rdata - req_reg;
                    end
                    else if (!sleep_reg)
                    begin
                        kind_next = mtsu_pkg::KIND_ERROR;
                        err_next  = mtsu_pkg::ERR_NO_SLEEP;
                    end
                    else if (qcount_reg >= QCNT_W'(QUEUE_DEPTH))
                    begin
                        kind_next = mtsu_pkg::KIND_ERROR;
                        err_next  = mtsu_pkg::ERR_QUEUE_FULL;
                    end
                    else
                    begin
                        q_we        = 1'b1;
                        qcount_next = qcount_reg + QCNT_W'(1);
                        kind_next   = mtsu_pkg::KIND_QUEUED;
                        whoo_next   = who_reg;
                    end
                end
            end

            ST_WALK:
            begin
                // Grant a waiter of this semaphore if it fits; otherwise copy it down to close gaps.
                q_raddr  = idx_inc[QAW-1:0];
                idx_next = idx_inc;
                if (take)
                begin
                    tok_next    = tok_after;
                    strobe_next = 1'b1;
                    kind_next   = mtsu_pkg::KIND_GRANTED;
                    whoo_next   = ent_who;
                    err_next    = mtsu_pkg::ERR_NONE;
                    toko_next   = tok_after;
                    last_next   = 1'b0;
                    if (tok_after == '0)
                    begin
                        grant_on_next = 1'b0;
                    end
                end
                else
                begin
                    q_we    = 1'b1;
                    q_waddr = wr_reg[QAW-1:0];
                    q_wdata = q_rdata;
                    wr_next = wr_reg + QCNT_W'(1);
                end
                if (idx_inc == qcount_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                sem_we      = 1'b1;
                sem_waddr   = SEM_AW'(sid_reg);
                sem_wdata   = tok_reg;
                qcount_next = wr_reg;
                strobe_next = 1'b1;
                kind_next   = mtsu_pkg::KIND_UNLOCK;
                semo_next   = sid_reg;
                whoo_next   = '0;
                err_next    = mtsu_pkg::ERR_NONE;
                toko_next   = tok_reg;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and registered result outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            created_reg  <= '0;
            qcount_reg   <= '0;
            idx_reg      <= '0;
            wr_reg       <= '0;
            grant_on_reg <= 1'b0;
            sleep_reg    <= 1'b1;
            unlock_reg   <= 1'b0;
            sid_reg      <= '0;
            req_reg      <= '0;
            who_reg      <= '0;
            tok_reg      <= '0;
            strobe_reg   <= 1'b0;
            kind_reg     <= mtsu_pkg::KIND_CREATED;
            semo_reg     <= '0;
            whoo_reg     <= '0;
            err_reg      <= mtsu_pkg::ERR_NONE;
            toko_reg     <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            created_reg  <= created_next;
            qcount_reg   <= qcount_next;
            idx_reg      <= idx_next;
            wr_reg       <= wr_next;
            grant_on_reg <= grant_on_next;
            sleep_reg    <= sleep_next;
            unlock_reg   <= unlock_next;
            sid_reg      <= sid_next;
            req_reg      <= req_next;
            who_reg      <= who_next;
            tok_reg      <= tok_next;
            strobe_reg   <= strobe_next;
            kind_reg     <= kind_next;
            semo_reg     <= semo_next;
            whoo_reg     <= whoo_next;
            err_reg      <= err_next;
            toko_reg     <= toko_next;
            last_reg     <= last_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign strobe        = strobe_reg;
    assign result_kind   = kind_reg;
    assign sem_out       = semo_reg;
    assign requester_out = whoo_reg;
    assign error_code    = err_reg;
    assign tokens_left   = toko_reg;
    assign last          = last_reg;

    // The walk pointer stays inside the filled part of the queue.
    `ASSERT_IMPLIES(a_walk_in_range, clk, rst_n, state_reg == ST_WALK, idx_reg < qcount_reg)
    // Compaction never writes ahead of the entry being read.
    `ASSERT_IMPLIES(a_wr_behind, clk, rst_n, state_reg == ST_WALK, wr_reg <= idx_reg)
    // Only wake-up grants come without the final-result mark.
    `ASSERT_IMPLIES(a_nonlast_grant, clk, rst_n, strobe_reg && !last_reg,
        kind_reg == mtsu_pkg::KIND_GRANTED)
    // The fill count never exceeds the queue depth.
    `ASSERT_IMPLIES(a_qcount_max, clk, rst_n, 1'b1, qcount_reg <= QCNT_W'(QUEUE_DEPTH))

endmodule

/* rtl/mtsu_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module mtsu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
